>>> rtl/bv_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the boot image verifier.
// No dependencies; every other rtl file but bv_if refers to it by scoped names.
package bv_pkg;

    localparam int HEADER_BYTES = 32;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int HDR_CRC_SPAN = 28;
    localparam int HDR_WORDS    = HEADER_BYTES / 4;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] ALL_ONES = 32'hffffffff;

    localparam logic [31:0] RST_LOAD_BASE  = 32'h87000000;
    localparam logic [31:0] RST_LOAD_LIMIT = 32'h87cdae00;
    localparam logic [31:0] RST_MAGIC      = 32'h434f4758;
    localparam logic [15:0] RST_VERSION    = 16'h0001;

    // configuration register indexes
    localparam logic [1:0] CFG_LOAD_BASE        = 2'd0;
    localparam logic [1:0] CFG_LOAD_LIMIT       = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_MAGIC   = 2'd2;
    localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd3;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_SHORT_READ = 2'd2;
    localparam logic [1:0] ST_CRC_BAD    = 2'd3;

    // result queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [31:0] write_address;
        logic [7:0]  write_byte;
        logic [1:0]  status;
        logic [31:0] entry_address;
        logic [31:0] clear_count;
        logic        last;
    } t_result;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic t_result verdict(input logic [1:0] st, input logic [31:0] entry,
                                        input logic [31:0] clear);
        t_result r;
        r.kind          = KIND_VERDICT;
        r.write_address = '0;
        r.write_byte    = '0;
        r.status        = st;
        r.entry_address = entry;
        r.clear_count   = clear;
        r.last          = 1'b1;
        return r;
    endfunction

endpackage

>>> rtl/bv_if.sv
// Request channel interfaces for the boot image verifier: image bytes in, results out.
// Depends on nothing but plain logic types.
interface bv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface bv_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] write_address;
    logic [7:0]  write_byte;
    logic [1:0]  status;
    logic [31:0] entry_address;
    logic [31:0] clear_count;
    logic        last;

    modport source (output valid, output kind, output write_address, output write_byte,
                    output status, output entry_address, output clear_count,
                    output last, input ready);
    modport sink (input valid, input kind, input write_address, input write_byte,
                  input status, input entry_address, input clear_count,
                  input last, output ready);
endinterface

>>> rtl/bv_core.sv
// Image parser: input register, configuration registers, header store, checks and CRC.
// Uses bv_pkg; pushes at most one result a cycle toward bv_outq.
module bv_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_eof,
    input  logic             i_q_ready,
    output logic             o_push,
    output bv_pkg::t_result  o_res
);

    logic [31:0] r_base, r_limit, r_magic;
    logic [15:0] r_version;

    logic        r_iv;
    logic [7:0]  r_ib;
    logic        r_ie;

    logic [7:0]  r_hdr [bv_pkg::HEADER_BYTES];
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_crc, n_crc;
    bv_pkg::t_phase r_phase, n_phase;

    logic            r_pend, n_pend;
    bv_pkg::t_result r_pv, n_pv;

    logic        w_fire;
    logic        w_hdr_last;
    logic        w_hdr_ok;
    logic [31:0] w_word [bv_pkg::HDR_WORDS];
    logic [31:0] w_crc_next;
    logic [31:0] w_cnt_inc;
    logic [32:0] w_end_sum;
    logic [31:0] w_room;

    // a held verdict only exists in the verdict-given phase, where no byte pushes a result
    assign w_fire     = r_iv && i_q_ready;
    assign o_in_ready = !r_iv || w_fire;

    // header words; the top byte of the last word is the byte now being taken
    always_comb begin
        for (int w = 0; w < bv_pkg::HDR_WORDS - 1; w++) begin
            w_word[w] = {r_hdr[4*w+3], r_hdr[4*w+2], r_hdr[4*w+1], r_hdr[4*w]};
        end
        w_word[bv_pkg::HDR_WORDS-1] = {r_ib, r_hdr[bv_pkg::HEADER_BYTES-2],
                                       r_hdr[bv_pkg::HEADER_BYTES-3],
                                       r_hdr[bv_pkg::HEADER_BYTES-4]};
    end

    assign w_crc_next = bv_pkg::crc_byte(r_crc, r_ib);
    assign w_cnt_inc  = r_cnt + 32'd1;
    assign w_hdr_last = (r_cnt == 32'(bv_pkg::HEADER_BYTES - 1));
    assign w_end_sum  = {1'b0, r_base} + {1'b0, w_word[5]};
    assign w_room     = r_limit - r_base;

    // entry < psize <= msize makes entry+base safe once base+msize does not wrap
    assign w_hdr_ok = (w_word[0] == r_magic)
                   && (w_word[1][15:0] == r_version)
                   && (w_word[1][31:16] == 16'(bv_pkg::HEADER_BYTES))
                   && (~r_crc == w_word[7])
                   && (w_word[2] == r_base)
                   && (w_word[4] != 32'd0)
                   && (w_word[5] >= w_word[4])
                   && (w_word[3] < w_word[4])
                   && (w_word[5] <= w_room)
                   && !w_end_sum[32];

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            unique case (r_phase)
                bv_pkg::PH_HEADER: begin
                    if (r_ie) begin
                        n_phase = bv_pkg::PH_HEADER;
                    end else if (w_hdr_last) begin
                        n_phase = w_hdr_ok ? bv_pkg::PH_PAYLOAD : bv_pkg::PH_DONE;
                    end
                end
                bv_pkg::PH_PAYLOAD: begin
                    if (r_ie) begin
                        n_phase = bv_pkg::PH_HEADER;
                    end else if (w_cnt_inc >= w_word[4]) begin
                        n_phase = bv_pkg::PH_DONE;
                    end
                end
                default: begin
                    if (r_ie) begin
                        n_phase = bv_pkg::PH_HEADER;
                    end
                end
            endcase
        end
    end

    // results, counters and CRC
    always_comb begin
        n_cnt  = r_cnt;
        n_crc  = r_crc;
        n_pend = r_pend;
        n_pv   = r_pv;
        o_push = 1'b0;
        o_res  = r_pv;
        if (r_pend) begin
            o_push = i_q_ready;
            n_pend = !i_q_ready;
        end
        if (w_fire) begin
            unique case (r_phase)
                bv_pkg::PH_HEADER, bv_pkg::PH_PAYLOAD: begin
                    if (r_ie) begin
                        o_push = 1'b1;
                        o_res  = bv_pkg::verdict(bv_pkg::ST_SHORT_READ, '0, '0);
                        n_cnt  = '0;
                        n_crc  = bv_pkg::ALL_ONES;
                    end else if (r_phase == bv_pkg::PH_HEADER) begin
                        n_cnt = w_cnt_inc;
                        if (r_cnt < 32'(bv_pkg::HDR_CRC_SPAN)) begin
                            n_crc = w_crc_next;
                        end
                        if (w_hdr_last) begin
                            if (w_hdr_ok) begin
                                n_cnt = '0;
                                n_crc = bv_pkg::ALL_ONES;
                            end else begin
                                o_push = 1'b1;
                                o_res  = bv_pkg::verdict(bv_pkg::ST_BAD_HEADER, '0, '0);
                            end
                        end
                    end else begin
                        o_push              = 1'b1;
                        o_res.kind          = bv_pkg::KIND_WRITE;
                        o_res.write_address = r_base + r_cnt;
                        o_res.write_byte    = r_ib;
                        o_res.status        = bv_pkg::ST_OK;
                        o_res.entry_address = '0;
                        o_res.clear_count   = '0;
                        o_res.last          = 1'b1;
                        n_cnt               = w_cnt_inc;
                        n_crc               = w_crc_next;
                        if (w_cnt_inc >= w_word[4]) begin
                            // final payload byte: hold the verdict in r_pv until the queue has space
                            o_res.last = 1'b0;
                            n_pend     = 1'b1;
                            if (~w_crc_next == w_word[6]) begin
                                n_pv = bv_pkg::verdict(bv_pkg::ST_OK, r_base + w_word[3],
                                                       w_word[5] - w_word[4]);
                            end else begin
                                n_pv = bv_pkg::verdict(bv_pkg::ST_CRC_BAD, '0, '0);
                            end
                        end
                    end
                end
                default: begin
                    if (r_ie) begin
                        n_cnt = '0;
                        n_crc = bv_pkg::ALL_ONES;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= bv_pkg::RST_LOAD_BASE;
            r_limit   <= bv_pkg::RST_LOAD_LIMIT;
            r_magic   <= bv_pkg::RST_MAGIC;
            r_version <= bv_pkg::RST_VERSION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bv_pkg::CFG_LOAD_BASE:        r_base    <= i_cfg_data;
                bv_pkg::CFG_LOAD_LIMIT:       r_limit   <= i_cfg_data;
                bv_pkg::CFG_EXPECTED_MAGIC:   r_magic   <= i_cfg_data;
                bv_pkg::CFG_EXPECTED_VERSION: r_version <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_cnt   <= '0;
            r_crc   <= bv_pkg::ALL_ONES;
            r_phase <= bv_pkg::PH_HEADER;
            r_pend  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_iv <= i_in_valid;
            end
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ib <= i_in_byte;
            r_ie <= i_in_eof;
        end
        r_pv <= n_pv;
        if (w_fire && !r_ie && r_phase == bv_pkg::PH_HEADER) begin
            r_hdr[r_cnt[bv_pkg::HDR_IDX_W-1:0]] <= r_ib;
        end
    end

endmodule

>>> rtl/bv_outq.sv
// Two-entry result queue that parts the parser from the output channel.
// Uses bv_pkg for the result type and depth.
module bv_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bv_pkg::t_result  i_res,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_pop,
    output bv_pkg::t_result  o_res
);

    bv_pkg::t_result            r_mem [bv_pkg::Q_DEPTH];
    logic [bv_pkg::Q_PTR_W-1:0] r_wp, r_rp;
    logic [bv_pkg::Q_CNT_W-1:0] r_cnt;
    logic                       w_pop;

    assign o_space = (r_cnt != bv_pkg::Q_CNT_W'(bv_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign w_pop   = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + bv_pkg::Q_CNT_W'(i_push) - bv_pkg::Q_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

endmodule

>>> rtl/boot_image_verifier.sv
// Boot image verifier. Bytes of an image file arrive one request per clock on i_in while
// i_in.ready is high; the first 32 form a header of eight little-endian words (magic,
// version and header size, load address, entry offset, payload size, memory size, payload
// CRC, header CRC). The header CRC-32 over bytes 0 to 27 runs while those bytes arrive, so
// the full check completes combinationally as the 32nd byte is taken. Payload bytes then
// leave on o_out as memory writes at load_base upward while the payload CRC-32 runs, and
// one verdict closes each image: ok (with entry address and clear count), bad header,
// short read or payload CRC mismatch. Throughput is one byte per clock with no gap while
// the queue has space: the verdict after the final payload write is registered and takes
// the single result push port when the queue has space, while a byte taken then (ignored,
// or end of file) causes no result. An accepted byte reaches its result through the input
// register, then a two-entry result queue. Stalls on o_out fill the queue and then hold
// the input. end_of_file ends an image early with a short read verdict and rearms after a
// verdict without a result. The user must write configuration on i_cfg_* only while no
// request is in flight; the block itself does not enforce it.
module boot_image_verifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    bv_in_if.sink        i_in,
    bv_out_if.source     o_out
);

    logic            w_push;
    logic            w_space;
    logic            w_valid;
    bv_pkg::t_result w_res_in;
    bv_pkg::t_result w_res_out;

    // parse, check and generate requests
    bv_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_in_byte  (i_in.data_byte),
        .i_in_eof   (i_in.end_of_file),
        .i_q_ready  (w_space),
        .o_push     (w_push),
        .o_res      (w_res_in)
    );

    // hold results until the sink takes them
    bv_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res_in),
        .o_space (w_space),
        .o_valid (w_valid),
        .i_pop   (o_out.ready),
        .o_res   (w_res_out)
    );

    assign o_out.valid         = w_valid;
    assign o_out.kind          = w_res_out.kind;
    assign o_out.write_address = w_res_out.write_address;
    assign o_out.write_byte    = w_res_out.write_byte;
    assign o_out.status        = w_res_out.status;
    assign o_out.entry_address = w_res_out.entry_address;
    assign o_out.clear_count   = w_res_out.clear_count;
    assign o_out.last          = w_res_out.last;

endmodule

>>> rtl/bv_checker.sv
// Port-level checks for boot_image_verifier and the bind that attaches them.
// Uses bv_pkg for kind and status codes.
module bv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [31:0] i_out_write_address,
    input logic [7:0]  i_out_write_byte,
    input logic [1:0]  i_out_status,
    input logic [31:0] i_out_entry_address,
    input logic [31:0] i_out_clear_count,
    input logic        i_out_last
);

    // a stalled request holds valid, kind, write address, write byte, status and last
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_write_address) && $stable(i_out_write_byte)
            && $stable(i_out_status) && $stable(i_out_last))
        else $error("output request changed while stalled");

    // a write without last is the final payload byte: its verdict comes right after
    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_kind == bv_pkg::KIND_WRITE && !i_out_last
            |=> i_out_valid && i_out_kind == bv_pkg::KIND_VERDICT)
        else $error("final payload write not followed by verdict");

    // verdicts always close their step; only ok carries addresses
    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == bv_pkg::KIND_VERDICT |->
            i_out_last && i_out_write_address == 32'd0 && i_out_write_byte == 8'd0
            && (i_out_status == bv_pkg::ST_OK
                || (i_out_entry_address == 32'd0 && i_out_clear_count == 32'd0)))
        else $error("malformed verdict");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind boot_image_verifier bv_checker u_bv_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_kind          (o_out.kind),
    .i_out_write_address (o_out.write_address),
    .i_out_write_byte    (o_out.write_byte),
    .i_out_status        (o_out.status),
    .i_out_entry_address (o_out.entry_address),
    .i_out_clear_count   (o_out.clear_count),
    .i_out_last          (o_out.last)
);
